FILE: rtl/stx_etx_frame_receiver_lrc_top_defines.svh
// ----------------------------------------------------------------------------
// STX/ETX frame receiver assertion macros
// Concurrent assertion wrappers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef STX_ETX_FRAME_RECEIVER_LRC_TOP_DEFINES_SVH
`define STX_ETX_FRAME_RECEIVER_LRC_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define STXR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stxr assertion failed");
// next-cycle implication, checked outside reset
`define STXR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stxr assertion failed");
`else
`define STXR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define STXR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/stxr_pkg.sv
// ----------------------------------------------------------------------------
// STX/ETX frame receiver package
// Framing constants, phase and status codes, config and result types.
// ----------------------------------------------------------------------------
package stxr_pkg;

  // framing bytes
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // result kinds
  localparam logic KIND_BODY   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // minimum overhead of a frame: stx, two length bytes, etx, lrc
  localparam logic [16:0] FRAME_OVERHEAD = 17'd5;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LENGTH_MODE = 2'd0,
    CFG_BIG_ENDIAN  = 2'd1,
    CFG_MAX_FRAME   = 2'd2
  } cfg_index_t;

  // receive phases
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LEN2 = 3'd2,
    PH_BODY = 3'd3,
    PH_ETX  = 3'd4,
    PH_LRC  = 3'd5
  } phase_t;

  // end-of-frame status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LRC_ERR  = 2'd1,
    ST_BAD_ETX  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic        length_mode;
    logic        length_big_endian;
    logic [16:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [1:0]  status;
    logic [15:0] cmd_word;
    logic [7:0]  sequence_number;
    logic [15:0] body_length;
  } result_t;

  // one bcd digit pair, invalid nibbles taken at face value (max 165)
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    bcd_value = {4'b0000, b[7:4]} * 8'd10 + {4'b0000, b[3:0]};
  endfunction

endpackage

FILE: rtl/stx_etx_frame_receiver_lrc_top.sv
// ----------------------------------------------------------------------------
// STX/ETX frame receiver with XOR LRC
// Hunts for STX, decodes the length, passes body bytes and reports status.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    rx_byte
//  out       out_valid / out_ready  kind, data_byte, byte_index, status,
//                                   cmd_word, sequence_number, body_length
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One byte per cycle while in_ready is high; with the output not stalled, a
// byte's result appears in the output register on the cycle after the byte is
// taken. The frame state is registered and updates with each byte taken.
// Synchronous reset returns to hunting with default configuration.
// A stalled output holds one result plus one skid entry; in_ready drops only
// when both are full.
`include "stx_etx_frame_receiver_lrc_top_defines.svh"

module stx_etx_frame_receiver_lrc_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_index,
  output logic [1:0]  status,
  output logic [15:0] cmd_word,
  output logic [7:0]  sequence_number,
  output logic [15:0] body_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  stxr_pkg::cfg_t    cfg;
  stxr_pkg::result_t res;
  stxr_pkg::result_t out_data;
  logic              res_valid;
  logic              byte_valid;
  logic              space;
  logic              out_body;
  logic              out_status;

  assign cfg_ready  = 1'b1;
  assign in_ready   = space;
  assign byte_valid = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.length_mode       <= 1'b0;
      cfg.length_big_endian <= 1'b1;
      cfg.max_frame_bytes   <= 17'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stxr_pkg::CFG_LENGTH_MODE: cfg.length_mode       <= cfg_data[0];
        stxr_pkg::CFG_BIG_ENDIAN:  cfg.length_big_endian <= cfg_data[0];
        stxr_pkg::CFG_MAX_FRAME:   cfg.max_frame_bytes   <= cfg_data;
        default: begin
          cfg.length_mode <= cfg.length_mode;
        end
      endcase
    end
  end

  stxr_frame_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  stxr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // result fields
  assign kind            = out_data.kind;
  assign data_byte       = out_data.data_byte;
  assign byte_index      = out_data.byte_index;
  assign status          = out_data.status;
  assign cmd_word        = out_data.cmd_word;
  assign sequence_number = out_data.sequence_number;
  assign body_length     = out_data.body_length;

  // checks
  assign out_body   = out_valid && (kind == stxr_pkg::KIND_BODY);
  assign out_status = out_valid && (kind == stxr_pkg::KIND_STATUS);

  `STXR_ASSERT_IMPLY(a_full_has_output, clk, rst, !in_ready, out_valid)
  `STXR_ASSERT_NEXT(a_skid_holds, clk, rst, !in_ready && !out_ready, !in_ready)
  `STXR_ASSERT_IMPLY(a_body_no_status, clk, rst, out_body, status == stxr_pkg::ST_OK)
  `STXR_ASSERT_IMPLY(a_status_no_data, clk, rst, out_status, !(|{data_byte, byte_index}))

endmodule

FILE: rtl/stxr_frame_fsm.sv
// ----------------------------------------------------------------------------
// STX/ETX frame receiver sequencer
// Phase register, length decode, body capture and lrc; one byte per cycle.
// ----------------------------------------------------------------------------
module stxr_frame_fsm (
  input  logic             clk,
  input  logic             rst,
  input  stxr_pkg::cfg_t   cfg,
  input  logic             byte_valid,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output stxr_pkg::result_t res
);

  stxr_pkg::phase_t phase, phase_next;
  logic [7:0]  length_first_byte, length_first_byte_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] body_count, body_count_next;
  logic [7:0]  lrc_accumulator, lrc_accumulator_next;
  logic [15:0] captured_command, captured_command_next;
  logic [7:0]  captured_sequence, captured_sequence_next;

  logic [15:0] len_bcd;
  logic [15:0] len_decoded;
  logic        too_long;
  logic        body_last;
  logic        is_stx;
  logic        is_etx;
  logic        res_hit;

  // length decode and frame checks
  assign len_bcd = 16'(stxr_pkg::bcd_value(length_first_byte)) * 16'd100
                 + 16'(stxr_pkg::bcd_value(rx_byte));

  always_comb begin
    if (!cfg.length_mode) begin
      len_decoded = len_bcd;
    end else if (cfg.length_big_endian) begin
      len_decoded = {length_first_byte, rx_byte};
    end else begin
      len_decoded = {rx_byte, length_first_byte};
    end
  end

  assign too_long  = ({1'b0, len_decoded} + stxr_pkg::FRAME_OVERHEAD) > cfg.max_frame_bytes;
  assign body_last = ({1'b0, body_count} + 17'd1) >= {1'b0, frame_length};
  assign is_stx    = (rx_byte == stxr_pkg::STX_BYTE);
  assign is_etx    = (rx_byte == stxr_pkg::ETX_BYTE);

  // next phase
  always_comb begin
    unique case (phase)
      stxr_pkg::PH_LEN1: phase_next = stxr_pkg::PH_LEN2;
      stxr_pkg::PH_LEN2: begin
        if (too_long) begin
          phase_next = stxr_pkg::PH_HUNT;
        end else if (len_decoded == 16'd0) begin
          phase_next = stxr_pkg::PH_ETX;
        end else begin
          phase_next = stxr_pkg::PH_BODY;
        end
      end
      stxr_pkg::PH_BODY: phase_next = body_last ? stxr_pkg::PH_ETX : stxr_pkg::PH_BODY;
      stxr_pkg::PH_ETX:  phase_next = is_etx ? stxr_pkg::PH_LRC : stxr_pkg::PH_HUNT;
      stxr_pkg::PH_LRC:  phase_next = stxr_pkg::PH_HUNT;
      default:           phase_next = is_stx ? stxr_pkg::PH_LEN1 : stxr_pkg::PH_HUNT;
    endcase
  end

  // frame state updates
  always_comb begin
    length_first_byte_next = length_first_byte;
    frame_length_next      = frame_length;
    body_count_next        = body_count;
    lrc_accumulator_next   = lrc_accumulator;
    captured_command_next  = captured_command;
    captured_sequence_next = captured_sequence;
    unique case (phase)
      stxr_pkg::PH_LEN1: begin
        length_first_byte_next = rx_byte;
        lrc_accumulator_next   = rx_byte;
      end
      stxr_pkg::PH_LEN2: begin
        lrc_accumulator_next = lrc_accumulator ^ rx_byte;
        frame_length_next    = len_decoded;
        body_count_next      = 16'd0;
      end
      stxr_pkg::PH_BODY: begin
        lrc_accumulator_next = lrc_accumulator ^ rx_byte;
        body_count_next      = body_count + 16'd1;
        if (body_count == 16'd0) begin
          captured_command_next = {rx_byte, captured_command[7:0]};
        end else if (body_count == 16'd1) begin
          captured_command_next = {captured_command[15:8], rx_byte};
        end else if (body_count == 16'd3) begin
          captured_sequence_next = rx_byte;
        end
      end
      stxr_pkg::PH_ETX: begin
        if (is_etx) begin
          lrc_accumulator_next = lrc_accumulator ^ rx_byte;
        end
      end
      stxr_pkg::PH_LRC: begin
        lrc_accumulator_next = lrc_accumulator;
      end
      default: begin
        if (is_stx) begin
          length_first_byte_next = 8'd0;
          frame_length_next      = 16'd0;
          body_count_next        = 16'd0;
          lrc_accumulator_next   = 8'd0;
          captured_command_next  = 16'd0;
          captured_sequence_next = 8'd0;
        end
      end
    endcase
  end

  // result for this byte, built from the updated frame state
  always_comb begin
    res_hit             = 1'b0;
    res.kind            = stxr_pkg::KIND_STATUS;
    res.data_byte       = 8'd0;
    res.byte_index      = 16'd0;
    res.status          = stxr_pkg::ST_OK;
    res.cmd_word        = captured_command_next;
    res.sequence_number = captured_sequence_next;
    res.body_length     = frame_length_next;
    unique case (phase)
      stxr_pkg::PH_LEN2: begin
        if (too_long) begin
          res_hit    = 1'b1;
          res.status = stxr_pkg::ST_TOO_LONG;
        end
      end
      stxr_pkg::PH_BODY: begin
        res_hit        = 1'b1;
        res.kind       = stxr_pkg::KIND_BODY;
        res.data_byte  = rx_byte;
        res.byte_index = body_count;
      end
      stxr_pkg::PH_ETX: begin
        if (!is_etx) begin
          res_hit    = 1'b1;
          res.status = stxr_pkg::ST_BAD_ETX;
        end
      end
      stxr_pkg::PH_LRC: begin
        res_hit    = 1'b1;
        res.status = (rx_byte == lrc_accumulator) ? stxr_pkg::ST_OK : stxr_pkg::ST_LRC_ERR;
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  assign res_valid = byte_valid && res_hit;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= stxr_pkg::PH_HUNT;
      length_first_byte <= 8'd0;
      frame_length      <= 16'd0;
      body_count        <= 16'd0;
      lrc_accumulator   <= 8'd0;
      captured_command  <= 16'd0;
      captured_sequence <= 8'd0;
    end else if (byte_valid) begin
      phase             <= phase_next;
      length_first_byte <= length_first_byte_next;
      frame_length      <= frame_length_next;
      body_count        <= body_count_next;
      lrc_accumulator   <= lrc_accumulator_next;
      captured_command  <= captured_command_next;
      captured_sequence <= captured_sequence_next;
    end
  end

endmodule

FILE: rtl/stxr_out_buf.sv
// ----------------------------------------------------------------------------
// STX/ETX frame receiver output buffer
// Output register with one skid entry; input side stalls only when full.
// ----------------------------------------------------------------------------
module stxr_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stxr_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output stxr_pkg::result_t out_data
);

  logic              main_valid;
  stxr_pkg::result_t main_data;
  logic              skid_valid;
  stxr_pkg::result_t skid_data;
  logic              drain;

  assign drain     = !main_valid || out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: dv/stxr_frame_checker.sv
// ----------------------------------------------------------------------------
// STX/ETX frame receiver checker
// Watches the byte, result and register channels, keeps its own copy of the
// frame decoder state, and compares every result transaction with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module stxr_frame_checker
  import stxr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic [15:0] byte_index,
  input  logic [1:0]  status,
  input  logic [15:0] cmd_word,
  input  logic [7:0]  sequence_number,
  input  logic [15:0] body_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          mismatches,
  output int          results_owed
);

  localparam int REPORT_LIMIT = 10;

  // decoder copy: registers and frame state
  cfg_t        regs;
  phase_t      rx_phase;
  logic [7:0]  len_first;
  logic [15:0] frame_len;
  logic [15:0] body_cnt;
  logic [7:0]  lrc;
  logic [15:0] cmd_capture;
  logic [7:0]  seq_capture;

  result_t     frame_results[$];
  result_t     seen;
  result_t     want;
  result_t     fresh;
  int          fault_total;
  int          result_serial;

  // one length byte taken as two decimal digits, nibbles at face value
  function automatic int digit_pair(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  // result carrying the current captures
  function automatic result_t snapshot(input logic k, input logic [7:0] d,
                                       input logic [15:0] idx, input status_t st);
    result_t r;
    r.kind            = k;
    r.data_byte       = d;
    r.byte_index      = idx;
    r.status          = st;
    r.cmd_word        = cmd_capture;
    r.sequence_number = seq_capture;
    r.body_length     = frame_len;
    return r;
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf("kind %0d data %02h index %0d status %0d cmd %04h seq %02h length %0d",
                     r.kind, r.data_byte, r.byte_index, r.status, r.cmd_word,
                     r.sequence_number, r.body_length);
  endfunction

  // advance the decoder by one received byte; returns 1 when a result is due
  function automatic bit decode_rx_byte(input logic [7:0] b, output result_t r);
    int          len;
    logic [15:0] idx;
    r = '0;
    decode_rx_byte = 1'b0;
    case (rx_phase)
      PH_LEN1: begin
        len_first = b;
        lrc       = b;
        rx_phase  = PH_LEN2;
      end
      PH_LEN2: begin
        lrc ^= b;
        if (regs.length_mode == 1'b0) begin
          len = digit_pair(len_first) * 100 + digit_pair(b);
        end else if (regs.length_big_endian) begin
          len = 32'({len_first, b});
        end else begin
          len = 32'({b, len_first});
        end
        frame_len = len[15:0];
        body_cnt  = '0;
        if (32'(frame_len) + 5 > 32'(regs.max_frame_bytes)) begin
          rx_phase       = PH_HUNT;
          r              = snapshot(KIND_STATUS, 8'h00, 16'h0000, ST_TOO_LONG);
          decode_rx_byte = 1'b1;
        end else begin
          rx_phase = (frame_len == 16'd0) ? PH_ETX : PH_BODY;
        end
      end
      PH_BODY: begin
        idx = body_cnt;
        lrc ^= b;
        if (idx == 16'd0) begin
          cmd_capture[15:8] = b;
        end else if (idx == 16'd1) begin
          cmd_capture[7:0] = b;
        end else if (idx == 16'd3) begin
          seq_capture = b;
        end
        body_cnt = idx + 16'd1;
        if (32'(idx) + 1 >= 32'(frame_len)) rx_phase = PH_ETX;
        r              = snapshot(KIND_BODY, b, idx, ST_OK);
        decode_rx_byte = 1'b1;
      end
      PH_ETX: begin
        if (b != ETX_BYTE) begin
          rx_phase       = PH_HUNT;
          r              = snapshot(KIND_STATUS, 8'h00, 16'h0000, ST_BAD_ETX);
          decode_rx_byte = 1'b1;
        end else begin
          lrc ^= b;
          rx_phase = PH_LRC;
        end
      end
      PH_LRC: begin
        rx_phase       = PH_HUNT;
        r              = snapshot(KIND_STATUS, 8'h00, 16'h0000,
                                  (b == lrc) ? ST_OK : ST_LRC_ERR);
        decode_rx_byte = 1'b1;
      end
      default: begin
        // hunting: only the start byte opens a frame
        if (b == STX_BYTE) begin
          rx_phase    = PH_LEN1;
          len_first   = '0;
          frame_len   = '0;
          body_cnt    = '0;
          lrc         = '0;
          cmd_capture = '0;
          seq_capture = '0;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
    endcase
  endfunction

  function automatic void note_fault(input string what);
    fault_total++;
    if (fault_total <= REPORT_LIMIT) $display("%s", what);
  endfunction

  // result transactions are retired before the byte taken on the same edge
  always @(posedge clk) begin
    if (rst) begin
      regs          = '{length_mode: 1'b0, length_big_endian: 1'b1,
                        max_frame_bytes: 17'd1024};
      rx_phase      = PH_HUNT;
      len_first     = '0;
      frame_len     = '0;
      body_cnt      = '0;
      lrc           = '0;
      cmd_capture   = '0;
      seq_capture   = '0;
      fault_total   = 0;
      result_serial = 0;
      frame_results.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_LENGTH_MODE: regs.length_mode       = cfg_data[0];
          CFG_BIG_ENDIAN:  regs.length_big_endian = cfg_data[0];
          CFG_MAX_FRAME:   regs.max_frame_bytes   = cfg_data;
          default: ;
        endcase
      end

      // compare the result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        seen.kind            = kind;
        seen.data_byte       = data_byte;
        seen.byte_index      = byte_index;
        seen.status          = status;
        seen.cmd_word        = cmd_word;
        seen.sequence_number = sequence_number;
        seen.body_length     = body_length;
        if (frame_results.size() == 0) begin
          note_fault($sformatf("result %0d arrived with none pending: %s",
                               result_serial, describe(seen)));
        end else begin
          want = frame_results.pop_front();
          if (seen !== want) begin
            note_fault($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                 result_serial, describe(want), describe(seen)));
          end
        end
        result_serial++;
      end

      // predict from the byte transaction
      if (in_valid && in_ready) begin
        if (decode_rx_byte(rx_byte, fresh)) frame_results.push_back(fresh);
      end
    end
    mismatches   <= fault_total;
    results_owed <= frame_results.size();
  end

endmodule

FILE: dv/tb_stx_etx_frame_receiver_lrc_top.sv
// ----------------------------------------------------------------------------
// STX/ETX frame receiver testbench
// Feeds a short directed byte stream, then random frames (mostly well formed,
// some with a bad LRC, a bad end byte or a cut body) under several length
// encodings and maximum frame sizes, with random idling on both sides and one
// long receiver hold-off. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_stx_etx_frame_receiver_lrc_top;
  import stxr_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 300;
  localparam int OPENING_SIZE = 24;

  typedef enum int {
    FLAW_NONE,
    FLAW_LRC,
    FLAW_ETX,
    FLAW_CUT
  } frame_flaw_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [1:0]  status;
  logic [15:0] cmd_word;
  logic [7:0]  sequence_number;
  logic [15:0] body_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  int          mismatches;
  int          results_owed;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          sent_bytes;
  int          stall_cycles;
  bit          hold_req;
  cfg_t        link_cfg;

  // noise, good frame, bad lrc, bad end byte, then a too-long bcd length
  logic [7:0] opening_bytes [OPENING_SIZE] = '{
    8'hFF, 8'h00,
    STX_BYTE, 8'h00, 8'h04, 8'hFF, STX_BYTE, 8'h00, 8'h5A, ETX_BYTE, 8'hA0,
    STX_BYTE, 8'h00, 8'h00, ETX_BYTE, 8'h7E,
    STX_BYTE, 8'h00, 8'h01, 8'hAB, 8'h05,
    STX_BYTE, 8'hA0, 8'h00
  };

  stx_etx_frame_receiver_lrc_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .data_byte       (data_byte),
    .byte_index      (byte_index),
    .status          (status),
    .cmd_word        (cmd_word),
    .sequence_number (sequence_number),
    .body_length     (body_length),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  stxr_frame_checker frame_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .data_byte       (data_byte),
    .byte_index      (byte_index),
    .status          (status),
    .cmd_word        (cmd_word),
    .sequence_number (sequence_number),
    .body_length     (body_length),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_owed    (results_owed)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one byte transaction; valid is left high for a back-to-back follow-up
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_bytes++;
  endtask

  // one register transaction, cfg_valid already high
  task automatic put_reg(input cfg_index_t idx, input logic [16:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // drain the block, let it settle, then write all three registers
  task automatic configure(input logic mode, input logic big_end,
                           input logic [16:0] max_bytes);
    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    put_reg(CFG_LENGTH_MODE, {16'h0000, mode});
    put_reg(CFG_BIG_ENDIAN, {16'h0000, big_end});
    put_reg(CFG_MAX_FRAME, max_bytes);
    cfg_valid <= 1'b0;
    link_cfg = '{length_mode: mode, length_big_endian: big_end, max_frame_bytes: max_bytes};
  endtask

  // two decimal digits, sometimes with an out-of-range low nibble of equal worth
  function automatic logic [7:0] bcd_pair(input int v);
    if (v >= 10 && v % 10 <= 5 && $urandom_range(1) == 1)
      return {4'(v / 10 - 1), 4'(10 + v % 10)};
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // one frame in the current length encoding, possibly flawed
  task automatic send_random_frame();
    int          body_len;
    int          room;
    int          pick;
    int          body_sent;
    frame_flaw_t flaw;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  lrc;
    logic [7:0]  b;
    room = int'(link_cfg.max_frame_bytes) - 5;
    pick = $urandom_range(99);
    if (pick < 70) begin
      body_len = $urandom_range(12);
    end else if (pick < 80) begin
      body_len = $urandom_range(40);
    end else if (pick < 83) begin
      body_len = $urandom_range(300, 100);
    end else if (pick < 90) begin
      body_len = room;
    end else begin
      body_len = room + 1 + $urandom_range(20);
    end
    // keep to what the encoding can carry and to short accepted bodies
    if (body_len > (link_cfg.length_mode ? 65535 : 9999)) body_len = $urandom_range(12);
    if (body_len <= room && body_len > 300) body_len = $urandom_range(12);

    pick = $urandom_range(99);
    if (pick < 75) begin
      flaw = FLAW_NONE;
    end else if (pick < 85) begin
      flaw = FLAW_LRC;
    end else if (pick < 93) begin
      flaw = FLAW_ETX;
    end else begin
      flaw = FLAW_CUT;
    end

    if (link_cfg.length_mode) begin
      {hi, lo} = 16'(body_len);
      if (!link_cfg.length_big_endian) {hi, lo} = {lo, hi};
    end else begin
      hi = bcd_pair(body_len / 100);
      lo = bcd_pair(body_len % 100);
    end

    send_byte(STX_BYTE);
    send_byte(hi);
    send_byte(lo);
    lrc = hi ^ lo;
    // a rejected length ends the frame after the header
    if (body_len <= room) begin
      body_sent = (flaw == FLAW_CUT) ? $urandom_range(body_len) : body_len;
      for (int i = 0; i < body_sent; i++) begin
        b = 8'($urandom);
        lrc ^= b;
        send_byte(b);
      end
      if (flaw == FLAW_ETX) begin
        b = 8'($urandom_range(255));
        if (b == ETX_BYTE) b = ~ETX_BYTE;
        send_byte(b);
      end else if (flaw != FLAW_CUT) begin
        send_byte(ETX_BYTE);
        lrc ^= ETX_BYTE;
        if (flaw == FLAW_LRC) lrc ^= 8'h01 << $urandom_range(7);
        send_byte(lrc);
      end
    end
  endtask

  // frames with occasional line noise in between
  task automatic run_frames(input int budget);
    int         start;
    logic [7:0] noise;
    start = sent_bytes;
    while (sent_bytes - start < budget) begin
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(3, 1)) begin
          noise = 8'($urandom);
          if (noise == STX_BYTE) noise = ETX_BYTE;
          send_byte(noise);
        end
      end
      send_random_frame();
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("tb_stx_etx_frame_receiver_lrc_top NOT OK");
    $finish;
  end

  // stimulus and verdict
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_LENGTH_MODE;
    cfg_data    = '0;
    hold_req    = 1'b0;
    sent_bytes  = 0;
    tx_idle_pct = 11;
    rx_idle_pct = 65;
    link_cfg    = '{length_mode: 1'b0, length_big_endian: 1'b1, max_frame_bytes: 17'd1024};
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed stream at reset settings
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    // sender idles lightly, receiver heavily
    configure(1'b0, 1'b1, 17'd1024);
    run_frames(PHASE_BYTES);
    configure(1'b1, 1'b1, 17'd5);
    run_frames(PHASE_BYTES);

    // the other way round
    tx_idle_pct = 65;
    rx_idle_pct = 11;
    configure(1'b1, 1'b0, 17'd40);
    run_frames(PHASE_BYTES);
    configure(1'b0, 1'b0, 17'd65540);
    run_frames(PHASE_BYTES);

    // no idling, with one long receiver hold-off to back up the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(1'b1, 1'b1, 17'd65540);
    hold_req = 1'b1;
    run_frames(PHASE_BYTES);
    configure(1'b0, 1'b1, 17'd12);
    run_frames(PHASE_BYTES);

    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_stx_etx_frame_receiver_lrc_top OK");
    end else begin
      $display("tb_stx_etx_frame_receiver_lrc_top NOT OK");
    end
    $finish;
  end

endmodule
